/* hw/rtl/four_wheel_pid_speed_control_top_macros.svh */
// assertion helpers for the speed control block
`ifndef FOUR_WHEEL_PID_SPEED_CONTROL_TOP_MACROS_SVH
`define FOUR_WHEEL_PID_SPEED_CONTROL_TOP_MACROS_SVH

// checked only outside reset
`define FWPID_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// checked at every edge, reset included
`define FWPID_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

/* hw/rtl/fwpid_pkg.sv */
package fwpid_pkg;

    localparam int WHEELS    = 4;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;
    localparam int GAIN_W    = 48;
    localparam int ACC_W     = 51;

    typedef struct packed {
        logic [15:0] kd;
        logic [15:0] ki;
        logic [15:0] kp;
    } t_gains;

    typedef t_gains [WHEELS-1:0] t_gain_set;

    localparam t_gain_set GAINS_RESET = {
        48'd6685440,
        48'd1318561645184,
        48'd1318563349171,
        48'd1318561645235
    };

    typedef struct packed {
        logic signed [15:0] target_0;
        logic signed [15:0] target_1;
        logic signed [15:0] target_2;
        logic signed [15:0] target_3;
        logic signed [15:0] measured_0;
        logic signed [15:0] measured_1;
        logic signed [15:0] measured_2;
        logic signed [15:0] measured_3;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] drive_0;
        logic signed [15:0] drive_1;
        logic signed [15:0] drive_2;
        logic signed [15:0] drive_3;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic ld2;
        logic ld3;
    } t_lane_ctrl;

endpackage

/* hw/rtl/fwpid_cfg.sv */
module fwpid_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwpid_pkg::ADDR_W-1:0]  paddr,
    input  logic [fwpid_pkg::DATA_W-1:0]  pwdata,
    output logic [fwpid_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output fwpid_pkg::t_gain_set          o_gains
);

    fwpid_pkg::t_gain_set r_gains;
    logic [1:0]           idx;

    assign idx    = paddr[fwpid_pkg::ADDR_W-1:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= fwpid_pkg::GAINS_RESET;
        end else if (psel && penable && pwrite) begin
            r_gains[idx] <= pwdata[fwpid_pkg::GAIN_W-1:0];
        end
    end

    assign prdata  = fwpid_pkg::DATA_W'(r_gains[idx]);
    assign o_gains = r_gains;

endmodule

/* hw/rtl/fwpid_lane.sv */
module fwpid_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fwpid_pkg::t_lane_ctrl i_ctrl,
    input  fwpid_pkg::t_gains     i_gains,
    input  logic signed [15:0]    i_target,
    input  logic signed [15:0]    i_measured,
    output logic signed [15:0]    o_drive
);

    logic signed [31:0] r_integ;
    logic signed [17:0] r_prev;

    logic               neg;
    logic [16:0]        mag;
    logic signed [17:0] err;
    logic signed [32:0] integ_sum;
    logic signed [31:0] n_integ;
    logic signed [18:0] diff;

    logic [16:0]        r_s1_mag;
    logic               r_s1_neg;
    logic signed [17:0] r_s1_err;
    logic signed [31:0] r_s1_integ;
    logic signed [18:0] r_s1_diff;

    logic signed [34:0] r_s2_pkp;
    logic signed [48:0] r_s2_pki;
    logic signed [35:0] r_s2_pkd;
    logic [24:0]        r_s2_ff;
    logic               r_s2_neg;

    logic signed [fwpid_pkg::ACC_W-1:0] r_s3_acc;
    logic                               r_s3_neg;

    logic signed [fwpid_pkg::ACC_W-1:0] adj;
    logic signed [fwpid_pkg::ACC_W-1:0] quo;
    logic signed [15:0]                 drv;

    always_comb begin
        neg       = i_target[15];
        mag       = neg ? (~{1'b1, i_target} + 17'd1) : {1'b0, i_target};
        err       = $signed({1'b0, mag}) - 18'(i_measured);
        integ_sum = 33'(r_integ) + 33'(err);
        if (integ_sum[32] != integ_sum[31]) begin
            n_integ = integ_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            n_integ = integ_sum[31:0];
        end
        diff = 19'(err) - 19'(r_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_ctrl.accept) begin
            r_integ <= n_integ;
            r_prev  <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_s1_mag   <= mag;
            r_s1_neg   <= neg;
            r_s1_err   <= err;
            r_s1_integ <= n_integ;
            r_s1_diff  <= diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld2) begin
            r_s2_pkp <= $signed({1'b0, i_gains.kp}) * r_s1_err;
            r_s2_pki <= $signed({1'b0, i_gains.ki}) * r_s1_integ;
            r_s2_pkd <= $signed({1'b0, i_gains.kd}) * r_s1_diff;
            r_s2_ff  <= {r_s1_mag, 8'd0};
            r_s2_neg <= r_s1_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld3) begin
            r_s3_acc <= fwpid_pkg::ACC_W'(r_s2_pkp) + fwpid_pkg::ACC_W'(r_s2_pki)
                      + fwpid_pkg::ACC_W'(r_s2_pkd)
                      + fwpid_pkg::ACC_W'($signed({1'b0, r_s2_ff}));
            r_s3_neg <= r_s2_neg;
        end
    end

    // truncate toward zero, clamp, then apply direction
    always_comb begin
        adj = r_s3_acc[fwpid_pkg::ACC_W-1] ? (r_s3_acc + fwpid_pkg::ACC_W'(255)) : r_s3_acc;
        quo = adj >>> 8;
        if (quo > fwpid_pkg::ACC_W'(32767)) begin
            drv = 16'sh7fff;
        end else if (quo < -fwpid_pkg::ACC_W'(32768)) begin
            drv = 16'sh8000;
        end else begin
            drv = quo[15:0];
        end
        if (!r_s3_neg) begin
            o_drive = drv;
        end else if (drv == 16'sh8000) begin
            o_drive = 16'sh7fff;
        end else begin
            o_drive = -drv;
        end
    end

endmodule

/* hw/rtl/fwpid_merge.sv */
module fwpid_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic                                   i_valid,
    input  logic [fwpid_pkg::WHEELS-1:0][15:0]     i_drives,
    output logic                                   o_valid,
    output fwpid_pkg::t_out_item                   o_item
);

    logic                 r_valid;
    fwpid_pkg::t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.drive_0 <= i_drives[0];
            r_item.drive_1 <= i_drives[1];
            r_item.drive_2 <= i_drives[2];
            r_item.drive_3 <= i_drives[3];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hw/rtl/four_wheel_pid_speed_control_top.sv */
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+--------------------------------
// in        | in  | i_in_valid / o_in_ready      | i_in_data  (targets, measured)
// out       | out | o_out_valid / i_out_ready    | o_out_data (four drives)
// gains     | in  | psel penable pwrite / pready | paddr pwdata prdata, 8 bytes each
//
// one request per cycle while output flows; results pass s1, s2, s3 and out register
// integral and last error update in the cycle a request is taken
// multiplies and the final sum sit in two further pipeline stages per wheel
// synchronous active-low reset clears wheel state and pipeline valids, loads reset gains
// a stalled output only holds the input back once every stage is full
module four_wheel_pid_speed_control_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fwpid_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fwpid_pkg::t_out_item          o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwpid_pkg::ADDR_W-1:0]  paddr,
    input  logic [fwpid_pkg::DATA_W-1:0]  pwdata,
    output logic [fwpid_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    fwpid_pkg::t_gain_set                   gains;
    fwpid_pkg::t_lane_ctrl                  ctrl;
    logic [fwpid_pkg::WHEELS-1:0][15:0]     targets;
    logic [fwpid_pkg::WHEELS-1:0][15:0]     measured;
    logic [fwpid_pkg::WHEELS-1:0][15:0]     drives;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic free1;
    logic free2;
    logic free3;
    logic free4;

    assign targets  = {i_in_data.target_3, i_in_data.target_2,
                       i_in_data.target_1, i_in_data.target_0};
    assign measured = {i_in_data.measured_3, i_in_data.measured_2,
                       i_in_data.measured_1, i_in_data.measured_0};

    assign free4 = !o_out_valid || i_out_ready;
    assign free3 = !r_v3 || free4;
    assign free2 = !r_v2 || free3;
    assign free1 = !r_v1 || free2;

    assign o_in_ready  = free1;
    assign ctrl.accept = i_in_valid && free1;
    assign ctrl.ld2    = free2;
    assign ctrl.ld3    = free3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_in_valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
        end
    end

    fwpid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (gains)
    );

    for (genvar w = 0; w < fwpid_pkg::WHEELS; w++) begin : g_lane
        fwpid_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_gains    (gains[w]),
            .i_target   (targets[w]),
            .i_measured (measured[w]),
            .o_drive    (drives[w])
        );
    end

    fwpid_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (free4),
        .i_valid  (r_v3),
        .i_drives (drives),
        .o_valid  (o_out_valid),
        .o_item   (o_out_data)
    );

endmodule

/* hw/rtl/fwpid_checker.sv */
`include "four_wheel_pid_speed_control_top_macros.svh"

module fwpid_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input fwpid_pkg::t_out_item o_out_data
);

    `FWPID_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid)
    `FWPID_ASSERT(a_ready_only_on_stall, i_clk, i_rst_n,
        !o_in_ready |-> (o_out_valid && !i_out_ready))
    `FWPID_ASSERT(a_out_held, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid)
    `FWPID_ASSERT(a_out_stable, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data))

endmodule

bind four_wheel_pid_speed_control_top fwpid_checker u_fwpid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* test/four_wheel_pid_speed_control_top_test.sv */
module four_wheel_pid_speed_control_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        GAINS_WHEEL0,
        GAINS_WHEEL1,
        GAINS_WHEEL2,
        GAINS_WHEEL3
    } t_gain_reg;

    localparam int REG_STRIDE     = 8;
    localparam int MAX_GAP        = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_TICKS    = 109;
    localparam int INTEGRAL_MAX   = 32'h7fff_ffff;
    localparam int INTEGRAL_MIN   = 32'h8000_0000;
    localparam logic signed [15:0] SPEED_CORNERS [6] = '{
        16'sd32767, -16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    fwpid_pkg::t_in_item                i_in_data;
    logic                               o_out_valid;
    logic                               i_out_ready;
    fwpid_pkg::t_out_item               o_out_data;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [fwpid_pkg::ADDR_W-1:0]       paddr;
    logic [fwpid_pkg::DATA_W-1:0]       pwdata;
    logic [fwpid_pkg::DATA_W-1:0]       prdata;
    logic                               pready;

    four_wheel_pid_speed_control_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // controller state as seen by the predictor
    fwpid_pkg::t_gain_set  wheel_gains = fwpid_pkg::GAINS_RESET;
    int                    wheel_integral [fwpid_pkg::WHEELS];
    int                    wheel_last_error [fwpid_pkg::WHEELS];
    fwpid_pkg::t_out_item  expected_drives [$];
    int                    mismatches = 0;
    int                    idle_cycles = 0;
    bit                    in_gaps_on = 1'b1;
    bit                    out_stalls_on = 1'b1;
    bit                    out_hold_pending = 1'b0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic fwpid_pkg::t_out_item predict_drives(fwpid_pkg::t_in_item req);
        logic signed [15:0] tgt [fwpid_pkg::WHEELS];
        logic signed [15:0] meas [fwpid_pkg::WHEELS];
        logic signed [15:0] drv [fwpid_pkg::WHEELS];
        longint mag, err, integ, sum, level;
        logic negative;
        tgt  = '{req.target_0, req.target_1, req.target_2, req.target_3};
        meas = '{req.measured_0, req.measured_1, req.measured_2, req.measured_3};
        for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
            negative = tgt[w] < 0;
            mag = negative ? -longint'(tgt[w]) : longint'(tgt[w]);
            err = mag - longint'(meas[w]);
            integ = clamp(longint'(wheel_integral[w]) + err,
                          longint'(INTEGRAL_MIN), longint'(INTEGRAL_MAX));
            wheel_integral[w] = int'(integ);
            sum = mag * 256 + longint'(wheel_gains[w].kp) * err
                + longint'(wheel_gains[w].ki) * integ
                + longint'(wheel_gains[w].kd) * (err - longint'(wheel_last_error[w]));
            wheel_last_error[w] = int'(err);
            level = clamp(sum / 256, -32768, 32767);
            if (negative) begin
                level = clamp(-level, -32768, 32767);
            end
            drv[w] = level[15:0];
        end
        return {drv[0], drv[1], drv[2], drv[3]};
    endfunction

    task automatic log_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic compare_drives(fwpid_pkg::t_out_item want, fwpid_pkg::t_out_item got);
        logic signed [15:0] want_d [fwpid_pkg::WHEELS];
        logic signed [15:0] got_d [fwpid_pkg::WHEELS];
        want_d = '{want.drive_0, want.drive_1, want.drive_2, want.drive_3};
        got_d  = '{got.drive_0, got.drive_1, got.drive_2, got.drive_3};
        for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
            if (got_d[w] !== want_d[w]) begin
                log_mismatch($sformatf("drive_%0d expected %0d, got %0d",
                                       w, want_d[w], got_d[w]));
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_check
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_drives.push_back(predict_drives(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_drives.size() == 0) begin
                    log_mismatch($sformatf("unexpected result %h", o_out_data));
                end else begin
                    compare_drives(expected_drives.pop_front(), o_out_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[four_wheel_pid_speed_control_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, plus one long hold when asked
    initial begin : drive_sink
        int stall;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold_pending) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_hold_pending = 1'b0;
            end
            stall = out_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_tick(fwpid_pkg::t_in_item req);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_drives();
        while (expected_drives.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [fwpid_pkg::ADDR_W-1:0] gain_addr(t_gain_reg r);
        return fwpid_pkg::ADDR_W'(REG_STRIDE * int'(r));
    endfunction

    task automatic write_gains(t_gain_reg r, fwpid_pkg::t_gains value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gain_addr(r);
        pwdata  <= fwpid_pkg::DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        wheel_gains[r] = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_gains(t_gain_reg r);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= gain_addr(r);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[fwpid_pkg::GAIN_W-1:0] !== wheel_gains[r]) begin
            log_mismatch($sformatf("%s read %h, expected %h",
                                   r.name(), prdata, wheel_gains[r]));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic fwpid_pkg::t_gains random_gains();
        fwpid_pkg::t_gains g;
        logic [15:0] raw [3];
        for (int k = 0; k < 3; k++) begin
            raw[k] = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 1024));
        end
        g.kp = raw[0];
        g.ki = raw[1];
        g.kd = raw[2];
        return g;
    endfunction

    function automatic fwpid_pkg::t_in_item random_tick();
        logic signed [15:0] tgt [fwpid_pkg::WHEELS];
        logic signed [15:0] meas [fwpid_pkg::WHEELS];
        int v;
        int mag;
        for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: begin
                    v = int'($urandom_range(0, 6000)) - 3000;
                    mag = (v < 0) ? -v : v;
                    tgt[w]  = v[15:0];
                    meas[w] = 16'(mag + int'($urandom_range(0, 400)) - 200);
                end
                4, 5: begin
                    tgt[w]  = 16'($urandom);
                    meas[w] = 16'($urandom);
                end
                default: begin
                    tgt[w]  = SPEED_CORNERS[$urandom_range(0, 5)];
                    meas[w] = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
                end
            endcase
        end
        return {tgt[0], tgt[1], tgt[2], tgt[3], meas[0], meas[1], meas[2], meas[3]};
    endfunction

    task automatic test_gain_registers();
        for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
            check_gains(t_gain_reg'(w));
        end
    endtask

    task automatic test_directed_ticks();
        logic signed [15:0] pair_tgt [16];
        logic signed [15:0] pair_meas [16];
        int p;
        pair_tgt  = '{16'sd0, 16'sd32767, 16'sd32767, 16'sh8000,
                      16'sh8000, -16'sd1, 16'sd0, 16'sd0,
                      -16'sd32767, 16'sd1, 16'sd100, -16'sd100,
                      -16'sd32767, 16'sd32767, -16'sd1, 16'sd0};
        pair_meas = '{16'sd0, 16'sd0, 16'sh8000, 16'sh8000,
                      16'sd32767, 16'sd32767, 16'sh8000, 16'sd32767,
                      16'sd0, 16'sd1, 16'sd90, -16'sd110,
                      16'sh8000, 16'sd32767, -16'sd1, 16'sd0};
        for (int k = 0; k < 16; k++) begin
            // rotate so every wheel sees every corner
            p = k;
            send_tick({pair_tgt[p], pair_tgt[(p + 1) % 16], pair_tgt[(p + 2) % 16],
                       pair_tgt[(p + 3) % 16], pair_meas[p], pair_meas[(p + 1) % 16],
                       pair_meas[(p + 2) % 16], pair_meas[(p + 3) % 16]});
        end
        release_input();
        wait_for_drives();
    endtask

    task automatic test_random_ticks();
        fwpid_pkg::t_gains g;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
                case (phase)
                    0:       g = '0;
                    1:       g = '1;
                    default: g = random_gains();
                endcase
                write_gains(t_gain_reg'(w), g);
                check_gains(t_gain_reg'(w));
            end
            in_gaps_on    = (phase % 4) != 3;
            out_stalls_on = (phase % 4) != 3 && phase != 5;
            for (int k = 0; k < PHASE_TICKS; k++) begin
                send_tick(random_tick());
            end
            release_input();
            wait_for_drives();
        end
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        in_gaps_on = 1'b0;
        out_hold_pending = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_tick(random_tick());
        end
        release_input();
        wait_for_drives();
        in_gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
            wheel_integral[w]   = 0;
            wheel_last_error[w] = 0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_gain_registers();
        test_directed_ticks();
        test_random_ticks();
        test_output_backpressure();

        wait_for_drives();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_drives.size() == 0) begin
            $display("[four_wheel_pid_speed_control_top] OK");
        end else begin
            $display("[four_wheel_pid_speed_control_top] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fwpid_pkg.sv
hw/rtl/fwpid_cfg.sv
hw/rtl/fwpid_lane.sv
hw/rtl/fwpid_merge.sv
hw/rtl/four_wheel_pid_speed_control_top.sv
hw/rtl/fwpid_checker.sv
test/four_wheel_pid_speed_control_top_test.sv
